// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL. Clock and reset names follow the
// project convention (aclk, aresetn active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- design/fbd_pkg.sv -----
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared types, codes and the CRC-8 (poly 0x07) byte update for the deframer.
// ----------------------------------------------------------------------------
package fbd_pkg;

    localparam int CFG_IDX_W   = 1;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = 1;
    localparam int FIFO_CNT_W  = 2;

    localparam logic [7:0] START_DELIM_RST = 8'h7E;
    localparam logic [7:0] END_DELIM_RST   = 8'h7F;
    localparam logic [7:0] CRC_POLY        = 8'h07;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_DELIM = 1'b0,
        REG_END_DELIM   = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_BAD = 2'd1,
        ST_NO_END  = 2'd2,
        ST_BAD_LEN = 2'd3
    } status_t;

    typedef struct packed {
        logic        is_verdict;
        logic [7:0]  frame_type;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_index;
        logic [15:0] frame_length;
        status_t     status;
    } result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- design/framed_byte_deframer_crc8_core.sv -----
// Path: a byte that yields a result is written into the queue at the accepting
//   edge; the output register loads it from the queue once that register is
//   empty or being drained, and only then does it show on m_*.
// Throughput: one byte per cycle; the parser takes a byte whenever the
//   two-entry result queue has room, independent of m_ready in that cycle.
// Reset: synchronous, active low; parser back to hunting, delimiters to 0x7E
//   and 0x7F, queue and output register emptied.
// ----------------------------------------------------------------------------
// framed_byte_deframer_crc8_core
// Delimited frame receiver with CRC-8 check; streams payload bytes and one
// verdict per frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module framed_byte_deframer_crc8_core import fbd_pkg::*; #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_verdict,
    output logic [7:0]           m_frame_type,
    output logic [7:0]           m_payload_byte,
    output logic [7:0]           m_byte_index,
    output logic [15:0]          m_frame_length,
    output logic [1:0]           m_status
);

    logic    push;
    result_t push_rec;
    logic    q_pop, q_not_empty, q_full;
    result_t q_head;
    result_t m_rec;

    assign s_ready = !q_full;

    fbd_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .push      (push),
        .push_rec  (push_rec)
    );

    fbd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head_rec  (q_head)
    );

    fbd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rec       (m_rec)
    );

    assign m_is_verdict   = m_rec.is_verdict;
    assign m_frame_type   = m_rec.frame_type;
    assign m_payload_byte = m_rec.payload_byte;
    assign m_byte_index   = m_rec.byte_index;
    assign m_frame_length = m_rec.frame_length;
    assign m_status       = m_rec.status;

    `ASSERT_CLK(a_no_push_when_full, push |-> !q_full, "result pushed into a full queue")
    `ASSERT_CLK(a_payload_st, m_valid && !m_is_verdict |-> m_status == ST_OK, "payload status")
    `ASSERT_ALWAYS(a_reset_out, (aresetn && !$past(aresetn)) |-> !m_valid, "valid out of reset")

endmodule

// ----- design/fbd_front.sv -----
// ----------------------------------------------------------------------------
// fbd_front
// Frame parser: tracks the frame phase, runs the CRC and pushes one result
// record into the queue for each payload byte and each verdict.
// ----------------------------------------------------------------------------
module fbd_front import fbd_pkg::*; #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    output logic                 push,
    output result_t              push_rec
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC     = 3'd5,
        PH_END     = 3'd6
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         start_delim_reg;
    logic [7:0]         end_delim_reg;
    logic [7:0]         held_type_reg, held_type_next;
    logic [15:0]        held_length_reg, held_length_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         crc_reg, crc_next;
    logic [7:0]         rx_crc_reg, rx_crc_next;

    logic               accept;
    logic [7:0]         byte_crc;
    logic [15:0]        len_new;
    logic [16:0]        cnt_inc;

    assign accept   = s_valid && s_ready;
    assign byte_crc = crc8_update((phase_reg == PH_TYPE) ? 8'h00 : crc_reg, s_rx_byte);
    assign len_new  = {s_rx_byte, held_length_reg[7:0]};
    assign cnt_inc  = 17'(count_reg) + 17'd1;

    always_comb begin
        phase_next       = phase_reg;
        held_type_next   = held_type_reg;
        held_length_next = held_length_reg;
        count_next       = count_reg;
        crc_next         = crc_reg;
        rx_crc_next      = rx_crc_reg;
        push             = 1'b0;
        push_rec         = '0;
        push_rec.frame_type   = held_type_reg;
        push_rec.frame_length = held_length_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_TYPE: begin
                    held_type_next = s_rx_byte;
                    crc_next       = byte_crc;
                    phase_next     = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    held_length_next = {8'h00, s_rx_byte};
                    crc_next         = byte_crc;
                    phase_next       = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    held_length_next = len_new;
                    crc_next         = byte_crc;
                    count_next       = '0;
                    if (len_new == 16'd0) begin
                        phase_next = PH_CRC;
                    end else if ({1'b0, len_new} <= MAX_LEN) begin
                        phase_next = PH_PAYLOAD;
                    end else begin
                        // oversized frame: report and resume hunting
                        phase_next            = PH_HUNT;
                        push                  = 1'b1;
                        push_rec.is_verdict   = 1'b1;
                        push_rec.frame_length = len_new;
                        push_rec.status       = ST_BAD_LEN;
                    end
                end
                PH_PAYLOAD: begin
                    crc_next   = byte_crc;
                    count_next = CNT_W'(cnt_inc);
                    if (cnt_inc >= {1'b0, held_length_reg}) begin
                        phase_next = PH_CRC;
                    end
                    push                  = 1'b1;
                    push_rec.payload_byte = s_rx_byte;
                    push_rec.byte_index   = 8'(count_reg);
                end
                PH_CRC: begin
                    rx_crc_next = s_rx_byte;
                    phase_next  = PH_END;
                end
                PH_END: begin
                    phase_next          = PH_HUNT;
                    push                = 1'b1;
                    push_rec.is_verdict = 1'b1;
                    if (s_rx_byte != end_delim_reg) begin
                        push_rec.status = ST_NO_END;
                    end else if (crc_reg != rx_crc_reg) begin
                        push_rec.status = ST_CRC_BAD;
                    end else begin
                        push_rec.status = ST_OK;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                    if (s_rx_byte == start_delim_reg) begin
                        crc_next   = 8'h00;
                        phase_next = PH_TYPE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            start_delim_reg <= START_DELIM_RST;
            end_delim_reg   <= END_DELIM_RST;
            held_type_reg   <= '0;
            held_length_reg <= '0;
            count_reg       <= '0;
            crc_reg         <= '0;
            rx_crc_reg      <= '0;
        end else begin
            phase_reg       <= phase_next;
            held_type_reg   <= held_type_next;
            held_length_reg <= held_length_next;
            count_reg       <= count_next;
            crc_reg         <= crc_next;
            rx_crc_reg      <= rx_crc_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_START_DELIM: start_delim_reg <= cfg_wdata;
                    REG_END_DELIM:   end_delim_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- design/fbd_fifo.sv -----
// ----------------------------------------------------------------------------
// fbd_fifo
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module fbd_fifo import fbd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_rec,
    input  logic    pop,
    output logic    not_empty,
    output logic    full,
    output result_t head_rec
);

    result_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                   do_push, do_pop;

    localparam logic [FIFO_PTR_W-1:0] LAST_PTR = FIFO_PTR_W'(FIFO_DEPTH - 1);
    localparam logic [FIFO_CNT_W-1:0] FULL_CNT = FIFO_CNT_W'(FIFO_DEPTH);

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == FULL_CNT);
    assign head_rec  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/fbd_back.sv -----
// ----------------------------------------------------------------------------
// fbd_back
// Output register: pulls records from the queue and presents them on the
// result channel until the transaction completes.
// ----------------------------------------------------------------------------
module fbd_back import fbd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_not_empty,
    input  result_t q_head,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_rec
);

    logic    valid_reg;
    result_t rec_reg;

    // load whenever the register is empty or being drained this cycle
    assign q_pop   = q_not_empty && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign m_rec   = rec_reg;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rec_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

endmodule
